// ===== sv/ipfd_pkg.sv =====
package ipfd_pkg;

    localparam logic [4:0] FRAME_RECORDS = 5'd18;
    localparam logic [4:0] COUNT_MAX     = 5'd31;
    localparam logic [4:0] PREAMBLE_POS  = 5'd1;

    localparam logic [1:0] KIND_TOGGLE = 2'd0;
    localparam logic [1:0] KIND_SPACE  = 2'd1;

    localparam logic [15:0] LONG_NOMINAL     = 16'd1500;
    localparam logic [15:0] SHORT_NOMINAL    = 16'd500;
    localparam logic [15:0] PREAMBLE_NOMINAL = 16'd6000;
    localparam logic [15:0] TOLERANCE        = 16'd100;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic REG_CODE_A = 1'b0;
    localparam logic REG_CODE_B = 1'b1;

    localparam logic [3:0] CODE_A_RESET = 4'd0;
    localparam logic [3:0] CODE_B_RESET = 4'd1;

    typedef struct packed {
        logic [1:0]  pulse_kind;
        logic [15:0] pulse_duration;
        logic        frame_end;
    } rec_t;

    typedef struct packed {
        logic [3:0] code_a;
        logic [3:0] code_b;
    } cfg_t;

    typedef struct packed {
        logic       frame_valid;
        logic [3:0] channel_code;
        logic [3:0] command_code;
    } res_t;

    function automatic logic strictly_inside(input logic [15:0] v, input logic [15:0] nominal);
        begin
            strictly_inside = (v > (nominal - TOLERANCE)) && (v < (nominal + TOLERANCE));
        end
    endfunction

endpackage

// ===== sv/ipfd_if.sv =====
interface ipfd_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  pulse_kind;
    logic [15:0] pulse_duration;
    logic        frame_end;

    modport source (output valid, pulse_kind, pulse_duration, frame_end, input ready);
    modport sink (input valid, pulse_kind, pulse_duration, frame_end, output ready);
endinterface

interface ipfd_res_if;
    logic       valid;
    logic       ready;
    logic       frame_valid;
    logic [3:0] channel_code;
    logic [3:0] command_code;

    modport source (output valid, frame_valid, channel_code, command_code, input ready);
    modport sink (input valid, frame_valid, channel_code, command_code, output ready);
endinterface

// ===== sv/ipfd_apb_regs.sv =====
module ipfd_apb_regs
    import ipfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [3:0] code_a_reg;
    logic [3:0] code_b_reg;
    logic       wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_a_reg <= CODE_A_RESET;
            code_b_reg <= CODE_B_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_CODE_A)
            begin
                code_a_reg <= pwdata[3:0];
            end
            else
            begin
                code_b_reg <= pwdata[3:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CODE_A)
        begin
            prdata[3:0] = code_a_reg;
        end
        else
        begin
            prdata[3:0] = code_b_reg;
        end
    end

    assign cfg.code_a = code_a_reg;
    assign cfg.code_b = code_b_reg;

endmodule

// ===== sv/ipfd_in_stage.sv =====
module ipfd_in_stage
    import ipfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  rec_t in_rec,
    output logic rec_valid,
    output rec_t rec,
    input  logic advance
);

    logic valid_reg;
    logic valid_next;
    rec_t rec_reg;
    logic load;

    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= in_rec;
        end
    end

    assign rec_valid = valid_reg;
    assign rec       = rec_reg;

endmodule

// ===== sv/ipfd_frame_core.sv =====
module ipfd_frame_core
    import ipfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic rec_valid,
    input  rec_t rec,
    output logic advance,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic [4:0]  count_reg;
    logic [4:0]  count_next;
    logic        err_reg;
    logic        err_next;
    logic [15:0] hold_reg;
    logic [15:0] hold_next;
    logic [7:0]  shift_reg;
    logic [7:0]  shift_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    res_t        res_reg;
    res_t        res_next;
    logic        bit_val;
    logic        chan_ok;
    logic        good;

    assign advance = rec_valid && (!rec.frame_end || !out_valid_reg || out_ready);

    // frame state update for one record
    always_comb
    begin
        err_next   = err_reg;
        hold_next  = hold_reg;
        shift_next = shift_reg;
        bit_val    = strictly_inside(hold_reg, LONG_NOMINAL) &&
                     (rec.pulse_duration > (SHORT_NOMINAL - TOLERANCE));
        if (count_reg >= FRAME_RECORDS)
        begin
            err_next = 1'b1;
        end
        else if (!count_reg[0])
        begin
            if (rec.pulse_kind != KIND_TOGGLE)
            begin
                err_next = 1'b1;
            end
            hold_next = rec.pulse_duration;
        end
        else
        begin
            if (rec.pulse_kind != KIND_SPACE)
            begin
                err_next = 1'b1;
            end
            if (count_reg == PREAMBLE_POS)
            begin
                if (!(strictly_inside(hold_reg, PREAMBLE_NOMINAL) &&
                      strictly_inside(rec.pulse_duration, SHORT_NOMINAL)))
                begin
                    err_next = 1'b1;
                end
            end
            else
            begin
                shift_next = {shift_reg[6:0], bit_val};
            end
        end
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 5'd1;

        chan_ok = (shift_next[7:4] == cfg.code_a) || (shift_next[7:4] == cfg.code_b);
        good    = !err_next && (count_reg == (FRAME_RECORDS - 5'd1)) && chan_ok;

        res_next.frame_valid  = good;
        res_next.channel_code = good ? shift_next[7:4] : 4'd0;
        res_next.command_code = good ? shift_next[3:0] : 4'd0;

        out_valid_next = out_valid_reg;
        if (advance && rec.frame_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            err_reg       <= 1'b0;
            hold_reg      <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                if (rec.frame_end)
                begin
                    count_reg <= '0;
                    err_reg   <= 1'b0;
                    hold_reg  <= '0;
                    shift_reg <= '0;
                end
                else
                begin
                    count_reg <= count_next;
                    err_reg   <= err_next;
                    hold_reg  <= hold_next;
                    shift_reg <= shift_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && rec.frame_end)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== sv/ir_pulse_frame_decoder_unit.sv =====
// a frame's last record passes the input register, then its result is held in the result register
// throughput: one pulse record transaction per cycle; a record with an end mark
// waits in the input register only while an earlier result is stalled
// records without an end mark give no result
// reset (rst_n low, asynchronous): frame state and valid flags clear,
// channel_code_a to 0 and channel_code_b to 1
module ir_pulse_frame_decoder_unit
    import ipfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ipfd_rec_if.sink              pulse_in,
    ipfd_res_if.source            frame_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;
    rec_t in_rec;
    rec_t rec;
    res_t out_res;
    logic rec_valid;
    logic advance;
    logic in_ready;
    logic out_valid;

    assign in_rec.pulse_kind     = pulse_in.pulse_kind;
    assign in_rec.pulse_duration = pulse_in.pulse_duration;
    assign in_rec.frame_end      = pulse_in.frame_end;
    assign pulse_in.ready        = in_ready;

    ipfd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipfd_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pulse_in.valid),
        .in_ready  (in_ready),
        .in_rec    (in_rec),
        .rec_valid (rec_valid),
        .rec       (rec),
        .advance   (advance)
    );

    ipfd_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rec_valid (rec_valid),
        .rec       (rec),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (frame_out.ready),
        .out_res   (out_res)
    );

    assign frame_out.valid        = out_valid;
    assign frame_out.frame_valid  = out_res.frame_valid;
    assign frame_out.channel_code = out_res.channel_code;
    assign frame_out.command_code = out_res.command_code;

endmodule

// ===== sv/ipfd_checker.sv =====
module ipfd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       frame_valid,
    input logic [3:0] channel_code,
    input logic [3:0] command_code,
    input logic       pready
);

    // stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({frame_valid, channel_code, command_code}))
        else $error("result dropped or changed while stalled");

    // invalid frame carries zero codes
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_valid |-> channel_code == 4'd0 && command_code == 4'd0)
        else $error("invalid frame with nonzero codes");

    // a new result follows an earlier input transaction
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching input transaction");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind ir_pulse_frame_decoder_unit ipfd_checker u_ipfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pulse_in.valid),
    .in_ready     (pulse_in.ready),
    .out_valid    (frame_out.valid),
    .out_ready    (frame_out.ready),
    .frame_valid  (frame_out.frame_valid),
    .channel_code (frame_out.channel_code),
    .command_code (frame_out.command_code),
    .pready       (pready)
);

// ===== verif/ipfd_frame_checker.sv =====
`timescale 1ns / 100ps

module ipfd_frame_checker
    import ipfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ipfd_rec_if                   pulse_mon,
    ipfd_res_if                   frame_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatch_count,
    output int                    pending_count
);

    localparam int REPORT_LIMIT = 10;

    cfg_t        channel_codes;
    logic [4:0]  rec_pos;
    logic        frame_bad;
    logic [15:0] toggle_len;
    logic [7:0]  decoded_bits;
    res_t        expected_frames[$];

    function automatic logic near_nominal(input logic [15:0] v, input logic [15:0] nominal);
        int lo;
        int hi;
        lo = int'(nominal) - int'(TOLERANCE);
        hi = int'(nominal) + int'(TOLERANCE);
        return (int'(v) > lo) && (int'(v) < hi);
    endfunction

    task automatic clear_frame_state();
        rec_pos      = '0;
        frame_bad    = 1'b0;
        toggle_len   = '0;
        decoded_bits = '0;
    endtask

    task automatic report(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // update the frame state for one record and queue the result on an end mark
    task automatic decode_record(input logic [1:0] kind, input logic [15:0] dur,
                                 input logic last);
        logic [4:0] pos;
        logic       bit_val;
        logic [3:0] chan;
        logic       ok;
        res_t       res;
        pos = rec_pos;
        if (pos >= FRAME_RECORDS)
        begin
            frame_bad = 1'b1;
        end
        else if (!pos[0])
        begin
            if (kind != KIND_TOGGLE)
            begin
                frame_bad = 1'b1;
            end
            toggle_len = dur;
        end
        else
        begin
            if (kind != KIND_SPACE)
            begin
                frame_bad = 1'b1;
            end
            if (pos == PREAMBLE_POS)
            begin
                if (!(near_nominal(toggle_len, PREAMBLE_NOMINAL) &&
                      near_nominal(dur, SHORT_NOMINAL)))
                begin
                    frame_bad = 1'b1;
                end
            end
            else
            begin
                bit_val = near_nominal(toggle_len, LONG_NOMINAL) &&
                          (int'(dur) > int'(SHORT_NOMINAL) - int'(TOLERANCE));
                decoded_bits = {decoded_bits[6:0], bit_val};
            end
        end
        if (rec_pos < COUNT_MAX)
        begin
            rec_pos = rec_pos + 5'd1;
        end
        if (last)
        begin
            chan = decoded_bits[7:4];
            ok = !frame_bad && (pos == FRAME_RECORDS - 5'd1) &&
                 (chan == channel_codes.code_a || chan == channel_codes.code_b);
            res.frame_valid  = ok;
            res.channel_code = ok ? chan : 4'd0;
            res.command_code = ok ? decoded_bits[3:0] : 4'd0;
            expected_frames.push_back(res);
            clear_frame_state();
        end
    endtask

    task automatic compare_result(input res_t got);
        res_t want;
        if (expected_frames.size() == 0)
        begin
            report($sformatf("result with no frame pending: valid=%0d chan=%0h cmd=%0h",
                             got.frame_valid, got.channel_code, got.command_code));
        end
        else
        begin
            want = expected_frames.pop_front();
            if (got.frame_valid !== want.frame_valid ||
                got.channel_code !== want.channel_code ||
                got.command_code !== want.command_code)
            begin
                report($sformatf({"frame result mismatch: expected valid=%0d chan=%0h ",
                                  "cmd=%0h, got valid=%0d chan=%0h cmd=%0h"},
                                 want.frame_valid, want.channel_code, want.command_code,
                                 got.frame_valid, got.channel_code, got.command_code));
            end
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        res_t got;
        if (!rst_n)
        begin
            channel_codes.code_a = CODE_A_RESET;
            channel_codes.code_b = CODE_B_RESET;
            clear_frame_state();
            expected_frames.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_CODE_A)
                begin
                    channel_codes.code_a = pwdata[3:0];
                end
                else
                begin
                    channel_codes.code_b = pwdata[3:0];
                end
            end
            if (pulse_mon.valid && pulse_mon.ready)
            begin
                decode_record(pulse_mon.pulse_kind, pulse_mon.pulse_duration,
                              pulse_mon.frame_end);
            end
            if (frame_mon.valid && frame_mon.ready)
            begin
                got.frame_valid  = frame_mon.frame_valid;
                got.channel_code = frame_mon.channel_code;
                got.command_code = frame_mon.command_code;
                compare_result(got);
            end
        end
        pending_count = expected_frames.size();
    end

endmodule

// ===== verif/ir_pulse_frame_decoder_unit_tb.sv =====
`timescale 1ns / 100ps

module ir_pulse_frame_decoder_unit_tb;
    import ipfd_pkg::*;

    localparam logic [1:0] KIND_OTHER    = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam int ITEMS_PER_PHASE = 360;
    localparam int HOLD_CYCLES     = 400;
    localparam int PRESSURE_ITEMS  = 60;
    localparam int SETTLE_CYCLES   = 5;
    localparam int WATCHDOG_LIMIT  = 5000;

    typedef enum {
        FRAME_CLEAN,
        FRAME_BAD_KIND,
        FRAME_BAD_PREAMBLE,
        FRAME_SHORT,
        FRAME_LONG
    } frame_fault_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int         mismatch_count;
    int         pending_count;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         items_sent     = 0;
    logic       hold_request   = 1'b0;
    logic [3:0] stim_code_a    = CODE_A_RESET;
    logic [3:0] stim_code_b    = CODE_B_RESET;

    ipfd_rec_if pulse_in();
    ipfd_res_if frame_out();

    ir_pulse_frame_decoder_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pulse_in  (pulse_in),
        .frame_out (frame_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    ipfd_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .pulse_mon      (pulse_in),
        .frame_mon      (frame_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] dur_near(input logic [15:0] nominal);
        return 16'(int'(nominal) - int'(TOLERANCE) + 1 +
                   int'($urandom_range(0, 2 * int'(TOLERANCE) - 2)));
    endfunction

    function automatic logic [15:0] dur_away(input logic [15:0] nominal);
        int lo;
        int hi;
        lo = int'(nominal) - int'(TOLERANCE);
        hi = int'(nominal) + int'(TOLERANCE);
        case ($urandom_range(0, 3))
            0: return 16'(lo);
            1: return 16'(hi);
            2: return 16'($urandom_range(0, lo));
            default: return 16'($urandom_range(hi, 65535));
        endcase
    endfunction

    function automatic logic [1:0] wrong_kind(input logic [1:0] kind);
        logic [1:0] k;
        k = 2'($urandom_range(0, 3));
        while (k == kind)
        begin
            k = 2'($urandom_range(0, 3));
        end
        return k;
    endfunction

    task automatic send_rec(input logic [1:0] kind, input logic [15:0] dur, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pulse_in.valid = 1'b0;
            @(negedge clk);
        end
        pulse_in.valid          = 1'b1;
        pulse_in.pulse_kind     = kind;
        pulse_in.pulse_duration = dur;
        pulse_in.frame_end      = last;
        @(posedge clk);
        while (!pulse_in.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_rec(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                     (i == count - 1) || ($urandom_range(0, 7) == 0));
        end
    endtask

    task automatic send_frame(input logic [3:0] chan, input logic [3:0] cmd,
                              input frame_fault_t fault);
        logic [7:0]  frame_bits;
        logic [15:0] toggle_dur;
        logic [15:0] space_dur;
        logic [1:0]  kind;
        int          pair;
        int          cut_at;
        int          bad_at;
        int          extra;
        frame_bits = {chan, cmd};
        cut_at = (fault == FRAME_SHORT) ? $urandom_range(0, 16) : 17;
        bad_at = (fault == FRAME_BAD_KIND) ? $urandom_range(0, 17) : -1;
        extra  = (fault == FRAME_LONG) ? $urandom_range(1, 16) : 0;
        for (int i = 0; i <= cut_at; i++)
        begin
            pair = i / 2;
            if (i % 2 == 0)
            begin
                if (pair == 0)
                begin
                    toggle_dur = dur_near(PREAMBLE_NOMINAL);
                    space_dur  = dur_near(SHORT_NOMINAL);
                    if (fault == FRAME_BAD_PREAMBLE)
                    begin
                        case ($urandom_range(0, 2))
                            0: toggle_dur = dur_away(PREAMBLE_NOMINAL);
                            1: space_dur = dur_away(SHORT_NOMINAL);
                            default:
                            begin
                                toggle_dur = dur_away(PREAMBLE_NOMINAL);
                                space_dur  = dur_away(SHORT_NOMINAL);
                            end
                        endcase
                    end
                end
                else if (frame_bits[8 - pair])
                begin
                    toggle_dur = dur_near(LONG_NOMINAL);
                    space_dur  = ($urandom_range(0, 3) == 0) ?
                                 16'($urandom_range(401, 65535)) :
                                 16'($urandom_range(401, 700));
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            toggle_dur = dur_away(LONG_NOMINAL);
                            space_dur  = 16'($urandom_range(0, 1000));
                        end
                        1:
                        begin
                            toggle_dur = dur_near(LONG_NOMINAL);
                            space_dur  = 16'($urandom_range(0, 400));
                        end
                        default:
                        begin
                            toggle_dur = dur_away(LONG_NOMINAL);
                            space_dur  = 16'($urandom_range(0, 400));
                        end
                    endcase
                end
                kind = KIND_TOGGLE;
            end
            else
            begin
                kind = KIND_SPACE;
            end
            if (i == bad_at)
            begin
                kind = wrong_kind(kind);
            end
            send_rec(kind, (i % 2 == 0) ? toggle_dur : space_dur,
                     (i == cut_at) && (extra == 0));
        end
        for (int e = 1; e <= extra; e++)
        begin
            send_rec(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)), e == extra);
        end
    endtask

    task automatic send_random_frame();
        logic [3:0] chan;
        int         pick;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: chan = stim_code_a;
            4, 5, 6, 7: chan = stim_code_b;
            default: chan = 4'($urandom_range(0, 15));
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            send_frame(chan, 4'($urandom_range(0, 15)), FRAME_CLEAN);
        end
        else if (pick < 70)
        begin
            send_frame(chan, 4'($urandom_range(0, 15)), FRAME_BAD_KIND);
        end
        else if (pick < 78)
        begin
            send_frame(chan, 4'($urandom_range(0, 15)), FRAME_BAD_PREAMBLE);
        end
        else if (pick < 86)
        begin
            send_frame(chan, 4'($urandom_range(0, 15)), FRAME_SHORT);
        end
        else if (pick < 93)
        begin
            send_frame(chan, 4'($urandom_range(0, 15)), FRAME_LONG);
        end
        else
        begin
            send_noise($urandom_range(1, 12));
        end
    endtask

    // let every outstanding frame result drain before touching the registers
    task automatic wait_idle();
        pulse_in.valid = 1'b0;
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [3:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = APB_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_channel_codes(input logic [3:0] code_a, input logic [3:0] code_b);
        apb_write(REG_CODE_A, code_a);
        apb_write(REG_CODE_B, code_b);
        stim_code_a = code_a;
        stim_code_b = code_b;
    endtask

    initial
    begin : result_sink
        frame_out.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request    = 1'b0;
                frame_out.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            frame_out.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pulse_in.valid && pulse_in.ready) || (frame_out.valid && frame_out.ready) ||
                (psel && penable))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int start_count;
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        pulse_in.valid          = 1'b0;
        pulse_in.pulse_kind     = KIND_TOGGLE;
        pulse_in.pulse_duration = '0;
        pulse_in.frame_end      = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, wrong kinds, short frames, one clean frame
        send_rec(KIND_RESERVED, 16'hFFFF, 1'b1);
        send_rec(KIND_OTHER, 16'h0000, 1'b1);
        send_rec(KIND_SPACE, SHORT_NOMINAL, 1'b1);
        send_frame(CODE_B_RESET, 4'hF, FRAME_CLEAN);
        send_rec(KIND_TOGGLE, 16'hFFFF, 1'b0);
        send_rec(KIND_SPACE, 16'h0000, 1'b1);
        wait_idle();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    set_channel_codes(4'hF, 4'h0);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    set_channel_codes(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    set_channel_codes(4'h0, 4'hF);
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    stim_code_a = 4'($urandom_range(0, 15));
                    set_channel_codes(stim_code_a, stim_code_a);
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            start_count = items_sent;
            while (items_sent - start_count < ITEMS_PER_PHASE)
            begin
                send_random_frame();
            end
            wait_idle();
        end

        // back-pressure: results pile up behind a long receiver hold-off
        set_channel_codes(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        send_noise(1);
        for (int i = 0; i < PRESSURE_ITEMS; i++)
        begin
            send_rec(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)), 1'b1);
        end
        wait_idle();

        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
